// ===== design/hbkq_pkg.sv =====
// shared types and constants for the boot keyboard key press queue
`default_nettype none

package hbkq_pkg;

    // default sizes
    localparam int RING_SLOTS_DEF = 8;
    localparam int KEY_SLOTS_DEF  = 6;

    // report layout
    localparam int MAX_KEY_SLOTS  = 6;
    localparam int MIN_REPORT_LEN = 8;
    localparam int LEN_W          = 7;

    // depth of the op queue between front and back
    localparam int OP_FIFO_DEPTH  = 2;

    // command codes
    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // empty key slot
    localparam logic [7:0] KEY_NONE = 8'h00;

    // input beat
    typedef struct packed {
        logic             command;
        logic [LEN_W-1:0] report_length;
        logic [7:0]       modifier_byte;
        logic [7:0]       key_slot_0;
        logic [7:0]       key_slot_1;
        logic [7:0]       key_slot_2;
        logic [7:0]       key_slot_3;
        logic [7:0]       key_slot_4;
        logic [7:0]       key_slot_5;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic       pop_valid;
        logic [7:0] popped_key;
        logic [7:0] popped_modifiers;
    } t_out_item;

    // classified op handed from front to back
    typedef struct packed {
        logic                          is_pop;
        logic [7:0]                    mods;
        logic [MAX_KEY_SLOTS-1:0][7:0] keys;
        logic [MAX_KEY_SLOTS-1:0]      fresh;
    } t_op;

    // handshake between op queue and back
    typedef struct packed {
        logic valid;
        logic take;
    } t_op_hs;

    // back sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PUSH,
        BK_POP
    } t_back_state;

endpackage

`default_nettype wire

// ===== design/hbkq_front.sv =====
// front: takes beats, finds newly pressed keys, tracks previous report
`default_nettype none

module hbkq_front #(
    parameter int KEY_SLOTS = hbkq_pkg::KEY_SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire hbkq_pkg::t_in_item i_item,
    output hbkq_pkg::t_op           o_op,
    output logic                    o_op_push
);

    logic [KEY_SLOTS-1:0][7:0]                    r_prev;
    logic [hbkq_pkg::MAX_KEY_SLOTS-1:0][7:0]      w_keys;
    logic [hbkq_pkg::MAX_KEY_SLOTS-1:0]           w_fresh;
    logic                                         w_long;

    // unpack the key slots
    assign w_keys = {i_item.key_slot_5, i_item.key_slot_4, i_item.key_slot_3,
                     i_item.key_slot_2, i_item.key_slot_1, i_item.key_slot_0};

    assign w_long = (i_item.report_length >= hbkq_pkg::LEN_W'(hbkq_pkg::MIN_REPORT_LEN));

    // a slot is new when nonzero and absent from the previous report
    always_comb begin
        logic held;
        w_fresh = '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            held = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                if (r_prev[j] == w_keys[i]) begin
                    held = 1'b1;
                end
            end
            w_fresh[i] = (w_keys[i] != hbkq_pkg::KEY_NONE) && !held;
        end
    end

    // classified op; short reports are dropped here
    always_comb begin
        o_op.is_pop = (i_item.command == hbkq_pkg::CMD_POP);
        o_op.mods   = i_item.modifier_byte;
        o_op.keys   = w_keys;
        o_op.fresh  = w_fresh;
        o_op_push   = i_accept && (o_op.is_pop || w_long);
    end

    // previous keys follow every long report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (o_op_push && !o_op.is_pop) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_prev[i] <= w_keys[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/hbkq_op_fifo.sv =====
// short op queue decoupling front from back
`default_nettype none

module hbkq_op_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire hbkq_pkg::t_op   i_op,
    output logic                 o_full,
    input  wire hbkq_pkg::t_op_hs i_hs,
    output logic                 o_valid,
    output hbkq_pkg::t_op        o_op
);

    localparam int Depth = hbkq_pkg::OP_FIFO_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    hbkq_pkg::t_op     r_mem [Depth];
    logic [PtrW-1:0]   r_wr;
    logic [PtrW-1:0]   r_rd;
    logic [CntW-1:0]   r_cnt;
    logic              w_wr_en;
    logic              w_rd_en;

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_hs.take && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_op;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_rd_en) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_wr_en && !w_rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_wr_en && w_rd_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // count never exceeds the depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(Depth))
        else $error("op queue count over depth");

    // the back only takes an op that is there
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hs.take |-> (o_valid && i_hs.valid))
        else $error("op taken from empty queue");

endmodule

`default_nettype wire

// ===== design/hbkq_back.sv =====
// back: key ring, serial pushes, pops into the result register
`default_nettype none

module hbkq_back #(
    parameter int RING_SLOTS = hbkq_pkg::RING_SLOTS_DEF,
    parameter int KEY_SLOTS  = hbkq_pkg::KEY_SLOTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_op_valid,
    input  wire hbkq_pkg::t_op       i_op,
    output hbkq_pkg::t_op_hs         o_hs,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output hbkq_pkg::t_out_item      o_result
);

    localparam int PtrW  = $clog2(RING_SLOTS);
    localparam int LeftW = $clog2(KEY_SLOTS + 1);

    hbkq_pkg::t_back_state r_state;
    hbkq_pkg::t_back_state n_state;

    hbkq_pkg::t_op         r_op;
    logic [LeftW-1:0]      r_left;
    logic [PtrW-1:0]       r_wr_ptr;
    logic [PtrW-1:0]       r_rd_ptr;
    logic [15:0]           r_ring [RING_SLOTS];
    logic [15:0]           r_rd_data;
    logic                  r_out_valid;
    hbkq_pkg::t_out_item   r_out;

    logic [PtrW-1:0]       w_wr_next;
    logic [PtrW-1:0]       w_rd_next;
    logic                  w_ring_full;
    logic                  w_ring_empty;
    logic                  w_ring_we;
    logic                  w_take;

    // ring pointer arithmetic
    assign w_wr_next    = (r_wr_ptr == PtrW'(RING_SLOTS - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign w_rd_next    = (r_rd_ptr == PtrW'(RING_SLOTS - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign w_ring_full  = (w_wr_next == r_rd_ptr);
    assign w_ring_empty = (r_wr_ptr == r_rd_ptr);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hbkq_pkg::BK_IDLE: begin
                if (i_op_valid && !i_op.is_pop) begin
                    n_state = hbkq_pkg::BK_PUSH;
                end else if (i_op_valid && !r_out_valid) begin
                    n_state = hbkq_pkg::BK_POP;
                end
            end
            hbkq_pkg::BK_PUSH: begin
                if (r_left == LeftW'(1)) begin
                    n_state = hbkq_pkg::BK_IDLE;
                end
            end
            hbkq_pkg::BK_POP: begin
                n_state = hbkq_pkg::BK_IDLE;
            end
            default: begin
                n_state = hbkq_pkg::BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        w_take    = 1'b0;
        w_ring_we = 1'b0;
        unique case (r_state)
            hbkq_pkg::BK_IDLE: begin
                w_take = i_op_valid && (!i_op.is_pop || !r_out_valid);
            end
            hbkq_pkg::BK_PUSH: begin
                w_ring_we = r_op.fresh[0] && !w_ring_full;
            end
            hbkq_pkg::BK_POP: begin
                w_take = 1'b0;
            end
            default: begin
                w_take = 1'b0;
            end
        endcase
    end

    assign o_hs.valid = i_op_valid;
    assign o_hs.take  = w_take;
    assign o_empty    = !r_out_valid;
    assign o_result   = r_out;

    // ring storage, registered read at the read pointer
    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            r_ring[r_wr_ptr] <= {r_op.keys[0], r_op.mods};
        end
        r_rd_data <= r_ring[r_rd_ptr];
    end

    // op register: slot 0 is the one being pushed
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op   <= i_op;
            r_left <= LeftW'(KEY_SLOTS);
        end else if (r_state == hbkq_pkg::BK_PUSH) begin
            r_op.keys  <= {hbkq_pkg::KEY_NONE, r_op.keys[hbkq_pkg::MAX_KEY_SLOTS-1:1]};
            r_op.fresh <= {1'b0, r_op.fresh[hbkq_pkg::MAX_KEY_SLOTS-1:1]};
            r_left     <= r_left - 1'b1;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == hbkq_pkg::BK_POP) begin
            if (w_ring_empty) begin
                r_out <= '0;
            end else begin
                r_out.pop_valid        <= 1'b1;
                r_out.popped_key       <= r_rd_data[15:8];
                r_out.popped_modifiers <= r_rd_data[7:0];
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hbkq_pkg::BK_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ring_we) begin
                r_wr_ptr <= w_wr_next;
            end
            if (r_state == hbkq_pkg::BK_POP) begin
                r_out_valid <= 1'b1;
                if (!w_ring_empty) begin
                    r_rd_ptr <= w_rd_next;
                end
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // a ring write never lands on the read slot
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ring_we |-> (w_wr_next != r_rd_ptr))
        else $error("ring overrun");

    // a pop only runs with the result register free
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hbkq_pkg::BK_POP) |-> !r_out_valid)
        else $error("result register overwritten");

    // pushes finish before the slot count runs out
    a_left_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hbkq_pkg::BK_PUSH) |-> (r_left != '0))
        else $error("push sequencer ran past last slot");

    // the read pointer moves only after a pop step
    a_rd_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_ptr != $past(r_rd_ptr)) |-> ($past(r_state) == hbkq_pkg::BK_POP))
        else $error("read pointer moved outside a pop");

endmodule

`default_nettype wire

// ===== design/hid_boot_key_press_queue.sv =====
// Boot keyboard key press queue, top level.
// Input channel (push/full): each beat is either a boot keyboard report
// (command 0) or a pop request (command 1). Reports shorter than 8 bytes
// are dropped. Each nonzero key slot absent from the previous report is
// written, with the report's modifier byte, into a ring of RING_SLOTS slots
// that holds at most RING_SLOTS-1 keys; writes to a full ring are lost.
// Result channel (empty/pop): one beat per pop request, pop_valid 0 with
// zero fields when the ring was empty. Reports give no result beat.
// Timing: the front classifies each beat combinationally into a two-entry
// op queue. The back takes an op in its idle state, then writes a report
// slot by slot (one ring write port, one slot per cycle) and serves a pop
// in its pop state from the registered ring read, loading the result
// register. full rises once both op queue entries are taken.
// Reset clears previous keys, the ring pointers and all queues; ring
// contents need no clearing. When the receiver holds off pop, the result
// stays in the output register, pops stall in the op queue and full
// follows, while reports queued ahead of a stalled pop still complete.
`default_nettype none

module hid_boot_key_press_queue #(
    parameter int RING_SLOTS = hbkq_pkg::RING_SLOTS_DEF,
    parameter int KEY_SLOTS  = hbkq_pkg::KEY_SLOTS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire hbkq_pkg::t_in_item   i_item,
    output logic                      empty,
    input  wire logic                 pop,
    output hbkq_pkg::t_out_item       o_result
);

    hbkq_pkg::t_op    w_front_op;
    logic             w_front_push;
    hbkq_pkg::t_op    w_head_op;
    logic             w_head_valid;
    hbkq_pkg::t_op_hs w_hs;
    logic             w_accept;

    assign w_accept = push && !full;

    // classification front
    hbkq_front #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_item    (i_item),
        .o_op      (w_front_op),
        .o_op_push (w_front_push)
    );

    // op queue
    hbkq_op_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_op    (w_front_op),
        .o_full  (full),
        .i_hs    (w_hs),
        .o_valid (w_head_valid),
        .o_op    (w_head_op)
    );

    // ring and result back end
    hbkq_back #(
        .RING_SLOTS (RING_SLOTS),
        .KEY_SLOTS  (KEY_SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_head_valid),
        .i_op       (w_head_op),
        .o_hs       (w_hs),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench for the boot keyboard key press queue: queued beats, predicted pops, field checks
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hbkq_pkg::*;

    localparam int RANDOM_BEATS = 950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 64;
    localparam int CALM_FROM    = 2000;
    localparam int CALM_TO      = 3500;
    localparam int STALL_PCT    = 24;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  i_item  = '0;
    logic      full;
    logic      empty;
    t_out_item o_result;

    // beats waiting to be offered, and pop results still owed
    t_in_item  to_send [$];
    t_out_item pops_owed [$];
    bit        in_busy = 1'b0;
    int        cycles  = 0;
    int        errors  = 0;

    // own copy of the key tracking state
    logic [7:0] held_keys [KEY_SLOTS_DEF];
    logic [7:0] ring_key  [RING_SLOTS_DEF];
    logic [7:0] ring_mod  [RING_SLOTS_DEF];
    int         ring_wr = 0;
    int         ring_rd = 0;

    hid_boot_key_press_queue i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // random stall, none during the calm stretch
    function automatic bit stall_now();
        if (cycles >= CALM_FROM && cycles < CALM_TO) begin
            return 1'b0;
        end
        return ($urandom_range(99) < STALL_PCT);
    endfunction

    // key code biased towards a small alphabet so reports overlap
    function automatic logic [7:0] rand_key();
        int r;
        r = $urandom_range(99);
        if (r < 30) begin
            return KEY_NONE;
        end else if (r < 80) begin
            return 8'($urandom_range(12, 1));
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic t_in_item report_beat(input logic [LEN_W-1:0] len,
                                             input logic [7:0] mods,
                                             input logic [7:0] k0, input logic [7:0] k1,
                                             input logic [7:0] k2, input logic [7:0] k3,
                                             input logic [7:0] k4, input logic [7:0] k5);
        t_in_item it;
        it.command       = CMD_REPORT;
        it.report_length = len;
        it.modifier_byte = mods;
        it.key_slot_0    = k0;
        it.key_slot_1    = k1;
        it.key_slot_2    = k2;
        it.key_slot_3    = k3;
        it.key_slot_4    = k4;
        it.key_slot_5    = k5;
        return it;
    endfunction

    function automatic t_in_item pop_beat();
        t_in_item it;
        it         = '0;
        it.command = CMD_POP;
        return it;
    endfunction

    // new-key detection and ring update for one accepted beat
    task automatic track_key_presses(input t_in_item it);
        logic [7:0] slots [KEY_SLOTS_DEF];
        t_out_item  res;
        bit         held;
        int         nxt;
        slots = '{it.key_slot_0, it.key_slot_1, it.key_slot_2,
                  it.key_slot_3, it.key_slot_4, it.key_slot_5};
        if (it.command == CMD_POP) begin
            res = '0;
            if (ring_rd != ring_wr) begin
                res.pop_valid        = 1'b1;
                res.popped_key       = ring_key[ring_rd];
                res.popped_modifiers = ring_mod[ring_rd];
                ring_rd              = (ring_rd + 1) % RING_SLOTS_DEF;
            end
            pops_owed.push_back(res);
        end else if (it.report_length >= MIN_REPORT_LEN) begin
            for (int i = 0; i < KEY_SLOTS_DEF; i++) begin
                if (slots[i] != KEY_NONE) begin
                    held = 1'b0;
                    for (int j = 0; j < KEY_SLOTS_DEF; j++) begin
                        if (held_keys[j] == slots[i]) begin
                            held = 1'b1;
                        end
                    end
                    nxt = (ring_wr + 1) % RING_SLOTS_DEF;
                    // full ring drops the key silently
                    if (!held && nxt != ring_rd) begin
                        ring_key[ring_wr] = slots[i];
                        ring_mod[ring_wr] = it.modifier_byte;
                        ring_wr           = nxt;
                    end
                end
            end
            held_keys = slots;
        end
    endtask

    // driver: offer beats and pop at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_busy) begin
                if (to_send.size() != 0 && !stall_now()) begin
                    i_item  <= to_send.pop_front();
                    push    <= 1'b1;
                    in_busy = 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
            pop <= !stall_now();
        end
    end

    // monitor: sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        t_out_item due;
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else if (i_rst_n) begin
            // result beat against the oldest owed pop
            if (pop && !empty) begin
                if (pops_owed.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none actual %p",
                             $realtime, o_result);
                    errors++;
                end else begin
                    due = pops_owed.pop_front();
                    if (o_result.pop_valid !== due.pop_valid) begin
                        $display("%0t: pop_valid expected %0b actual %0b",
                                 $realtime, due.pop_valid, o_result.pop_valid);
                        errors++;
                    end
                    if (o_result.popped_key !== due.popped_key) begin
                        $display("%0t: popped_key expected %02h actual %02h",
                                 $realtime, due.popped_key, o_result.popped_key);
                        errors++;
                    end
                    if (o_result.popped_modifiers !== due.popped_modifiers) begin
                        $display("%0t: popped_modifiers expected %02h actual %02h",
                                 $realtime, due.popped_modifiers, o_result.popped_modifiers);
                        errors++;
                    end
                end
            end
            // input beat taken
            if (push && !full) begin
                track_key_presses(i_item);
                in_busy = 1'b0;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        t_in_item   it;
        logic [7:0] keys [KEY_SLOTS_DEF];
        logic [7:0] last [KEY_SLOTS_DEF];
        logic [LEN_W-1:0] len;
        int         pop_pct;
        int         r;
        int         reuse;

        foreach (held_keys[i]) held_keys[i] = KEY_NONE;
        foreach (last[i]) last[i] = KEY_NONE;
        pop_pct = 40;

        // directed: empty pop, short reports, fill to full, drops, repeats
        to_send.push_back(pop_beat());
        to_send.push_back(report_beat(LEN_W'(7), 8'hFF, 8'h04, 8'h05, 8'h06, 8'h07,
                                      8'h08, 8'h09));
        to_send.push_back(pop_beat());
        to_send.push_back(report_beat(LEN_W'(0), 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                      8'hFF, 8'hFF));
        to_send.push_back(report_beat(LEN_W'(8), 8'hFF, 8'h04, 8'h05, 8'h06, 8'h07,
                                      8'h08, 8'h09));
        to_send.push_back(report_beat(LEN_W'(8), 8'hFF, 8'h04, 8'h05, 8'h06, 8'h07,
                                      8'h08, 8'h09));
        to_send.push_back(report_beat(LEN_W'(64), 8'h00, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
                                      8'h0E, 8'h0F));
        repeat (8) to_send.push_back(pop_beat());
        to_send.push_back(report_beat(LEN_W'(127), 8'h5A, 8'h20, 8'h20, 8'h00, 8'h00,
                                      8'h00, 8'hFF));
        to_send.push_back(report_beat(LEN_W'(3), 8'h11, 8'h30, 8'h31, 8'h32, 8'h33,
                                      8'h34, 8'h35));
        to_send.push_back(report_beat(LEN_W'(8), 8'hA5, 8'h20, 8'hFF, 8'h00, 8'h00,
                                      8'h00, 8'h00));
        to_send.push_back(report_beat(LEN_W'(8), 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                      8'h00, 8'h00));
        to_send.push_back(report_beat(LEN_W'(8), 8'h81, 8'h00, 8'h00, 8'h00, 8'h00,
                                      8'h00, 8'h20));
        repeat (5) to_send.push_back(pop_beat());

        // random: mostly well-formed reports that overlap, some noise
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 50 == 0) begin
                pop_pct = $urandom_range(65, 20);
            end
            r = $urandom_range(99);
            if (r < pop_pct) begin
                it         = {$urandom(), $urandom()};
                it.command = CMD_POP;
            end else begin
                r = $urandom_range(99);
                if (r < 8) begin
                    it         = {$urandom(), $urandom()};
                    it.command = CMD_REPORT;
                end else if (r < 14) begin
                    it               = {$urandom(), $urandom()};
                    it.command       = CMD_REPORT;
                    it.report_length = LEN_W'($urandom_range(MIN_REPORT_LEN - 1, 0));
                end else begin
                    reuse = ($urandom_range(99) < 50);
                    for (int i = 0; i < KEY_SLOTS_DEF; i++) begin
                        if (reuse && $urandom_range(99) < 75) begin
                            keys[i] = last[i];
                        end else begin
                            keys[i] = rand_key();
                        end
                    end
                    if ($urandom_range(9) == 0) begin
                        len = LEN_W'($urandom_range(127, MIN_REPORT_LEN));
                    end else begin
                        len = LEN_W'(MIN_REPORT_LEN);
                    end
                    it   = report_beat(len, 8'($urandom_range(255)), keys[0], keys[1],
                                       keys[2], keys[3], keys[4], keys[5]);
                    last = keys;
                end
            end
            to_send.push_back(it);
        end

        // hold reset at the start, then release it
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every beat to go in and every owed pop to come out
        while (to_send.size() != 0 || in_busy || pops_owed.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/hbkq_pkg.sv
design/hbkq_front.sv
design/hbkq_op_fifo.sv
design/hbkq_back.sv
design/hid_boot_key_press_queue.sv
dv/testbench.sv
